// File: rtl/ogr_pkg.sv
package ogr_pkg;

  localparam int GridSideDef    = 256;
  localparam int MaxRayStepsDef = 1024;

  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int ValW     = 7;
  localparam int PoseW    = 24;
  localparam int AngW     = 16;
  localparam int RangeW   = 20;
  localparam int QueryW   = 8;

  // CORDIC datapath
  localparam int TrigW    = 18;
  localparam int CordW    = 34;
  localparam int ZW       = 18;
  localparam int Iters    = 16;
  localparam logic signed [CordW-1:0] CordicK = 34'sd652032874;

  localparam logic [15:0] InvCellRst   = 16'd1024;
  localparam logic [15:0] CellSizeRst  = 16'd1024;
  localparam logic [15:0] RayStepRst   = 16'd410;
  localparam logic [6:0]  MissDecRst   = 7'd2;
  localparam logic [6:0]  HitIncRst    = 7'd5;
  localparam logic [6:0]  CellMaxRst   = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INV_CELL  = 3'd0,
    CFG_CELL_SIZE = 3'd1,
    CFG_RAY_STEP  = 3'd2,
    CFG_MISS_DEC  = 3'd3,
    CFG_HIT_INC   = 3'd4,
    CFG_CELL_MAX  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QADDR,
    ST_QDATA,
    ST_PX,
    ST_PY,
    ST_TRIG,
    ST_CHECK,
    ST_DC,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_RND,
    ST_ADDR,
    ST_MOD
  } state_e;

  typedef struct packed {
    logic                    done;
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } trig_t;

  // atan(2^-i) in binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ogr_if.sv
interface ogr_in_if;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [23:0]      pose_x;
  logic signed [23:0]      pose_y;
  logic [15:0]             pose_heading;
  logic [15:0]             beam_angle;
  logic [19:0]             beam_range;
  logic signed [7:0]       query_x;
  logic signed [7:0]       query_y;

  modport source (output valid, req_type, pose_x, pose_y, pose_heading, beam_angle,
                  beam_range, query_x, query_y, input ready);
  modport sink (input valid, req_type, pose_x, pose_y, pose_heading, beam_angle,
                beam_range, query_x, query_y, output ready);
endinterface

interface ogr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_value;
  logic       in_window;

  modport source (output valid, cell_value, in_window, input ready);
  modport sink (input valid, cell_value, in_window, output ready);
endinterface

// File: rtl/ogr_cordic.sv
module ogr_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         angle_i,
  output ogr_pkg::trig_t      trig_o
);

  localparam int CordW = ogr_pkg::CordW;
  localparam int ZW    = ogr_pkg::ZW;
  localparam int TrigW = ogr_pkg::TrigW;

  logic                    run_q, fin_q, done_q, neg_q;
  logic [3:0]              it_q;
  logic signed [CordW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0]    z_q, z_d, z0;
  logic signed [ZW-1:0]    at;
  logic                    neg0;
  logic signed [TrigW-1:0] cos_q, sin_q, xr, yr;

  // round half away from zero, drop 14 bits
  function automatic logic signed [TrigW-1:0] rnd14(input logic signed [CordW-1:0] v);
    logic [CordW-1:0] m;
    logic [CordW-1:0] s;
    logic signed [TrigW-1:0] r;
    m = v[CordW-1] ? CordW'(-v) : CordW'(v);
    s = m + CordW'(8192);
    r = $signed({1'b0, s[30:14]});
    return v[CordW-1] ? -r : r;
  endfunction

  // fold into the right half plane
  always_comb begin
    z0   = ZW'($signed(angle_i));
    neg0 = 1'b0;
    if (z0 > ZW'(16384)) begin
      z0   = z0 - ZW'(32768);
      neg0 = 1'b1;
    end else if (z0 < -ZW'(16384)) begin
      z0   = z0 + ZW'(32768);
      neg0 = 1'b1;
    end
  end

  // shared shifter: one micro-rotation per cycle
  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = $signed({4'b0, ogr_pkg::atan_lut(it_q)});
    if (!z_q[ZW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
    xr = rnd14(x_q);
    yr = rnd14(y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else if (run_q) begin
      it_q <= it_q + 4'd1;
      if (it_q == 4'(ogr_pkg::Iters - 1)) begin
        run_q <= 1'b0;
        fin_q <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= ogr_pkg::CordicK;
      y_q   <= '0;
      z_q   <= z0;
      neg_q <= neg0;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end else if (fin_q) begin
      cos_q <= neg_q ? -xr : xr;
      sin_q <= neg_q ? -yr : yr;
    end
  end

  assign trig_o = '{done: done_q, cos_v: cos_q, sin_v: sin_q};

endmodule

// File: rtl/occupancy_grid_ray_update_unit.sv
// Occupancy grid with ray-cast updates.
// Input channel in_i carries one item: a hit (req_type 0: pose, beam angle and range)
// or a read (req_type 1: one cell index). A hit walks the beam in ray_step increments,
// lowering each distinct free cell and raising the end cell; it gives no result.
// A read gives one result item on out_o: the cell value and an in-window flag.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// Steps: a read passes ST_QADDR (grid read) and ST_QDATA (result registered). A hit
// first scales the pose (ST_PX, ST_PY) and runs 16 CORDIC rotations, then for each
// beam sample goes through ST_CHECK, the ST_DC..ST_RND steps once per axis and ST_ADDR,
// plus ST_MOD if the sample updates a cell; the end cell is handled the same way.
// Every sample runs through one shared 26x18 multiplier, six products per sample;
// that multiplier and the single grid memory port set the rate.
// in_i.ready is high only while the sequencer is idle.
// After reset the grid is swept to zero, one entry per cycle, over all
// 2^(2*ceil(log2(GRID_SIDE))) entries (65536 at the default size); no item is taken
// meanwhile, configuration writes are.
// A result waits in an output register while out_o.ready is low; the block keeps
// taking items, and a second read result stalls the sequencer until the first leaves.
module occupancy_grid_ray_update_unit #(
  parameter int GRID_SIDE     = ogr_pkg::GridSideDef,
  parameter int MAX_RAY_STEPS = ogr_pkg::MaxRayStepsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ogr_in_if.sink                       in_i,
  ogr_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [ogr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ogr_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int AW    = $clog2(GRID_SIDE);
  localparam int MW    = 2 * AW;
  localparam int Depth = 1 << MW;
  localparam int Half  = GRID_SIDE / 2;
  localparam int NW    = $clog2(MAX_RAY_STEPS + 1);
  localparam int CW    = 24;
  localparam int DW    = 21;
  localparam int PW    = 44;
  localparam int BW    = 42;
  localparam int AccW  = 60;
  localparam int VW    = ogr_pkg::ValW;

  // configuration
  logic [15:0]   inv_cell_q, cell_size_q, ray_step_q;
  logic [VW-1:0] miss_dec_q, hit_inc_q, cell_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_cell_q  <= ogr_pkg::InvCellRst;
      cell_size_q <= ogr_pkg::CellSizeRst;
      ray_step_q  <= ogr_pkg::RayStepRst;
      miss_dec_q  <= ogr_pkg::MissDecRst;
      hit_inc_q   <= ogr_pkg::HitIncRst;
      cell_max_q  <= ogr_pkg::CellMaxRst;
    end else if (cfg_we_i) begin
      unique case (ogr_pkg::cfg_idx_e'(cfg_idx_i))
        ogr_pkg::CFG_INV_CELL:  inv_cell_q  <= cfg_data_i;
        ogr_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_data_i;
        ogr_pkg::CFG_RAY_STEP:  ray_step_q  <= cfg_data_i;
        ogr_pkg::CFG_MISS_DEC:  miss_dec_q  <= cfg_data_i[VW-1:0];
        ogr_pkg::CFG_HIT_INC:   hit_inc_q   <= cfg_data_i[VW-1:0];
        ogr_pkg::CFG_CELL_MAX:  cell_max_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  ogr_pkg::state_e state_q, state_d;

  logic                   in_acc;
  ogr_pkg::trig_t         trig;

  logic signed [23:0]     px_q, py_q;
  logic [19:0]            range_q;
  logic [DW-1:0]          dist_q, d_q;
  logic [NW-1:0]          n_q;
  logic                   axis_q, final_q, last_valid_q, qwin_q;
  logic [MW-1:0]          last_addr_q, clr_q;
  logic signed [PW-1:0]   prod_q, mul_p;
  logic signed [25:0]     mul_a;
  logic signed [17:0]     mul_b;
  logic signed [38:0]     dc_q;
  logic signed [BW-1:0]   basex_q, basey_q, base_sel;
  logic signed [AccW-1:0] acc_q;
  logic signed [CW-1:0]   cx_q, cy_q, cell_rnd;
  logic                   out_valid_q, out_win_q;
  logic [VW-1:0]          out_val_q;

  logic                   in_win, skip, more;
  logic [AW-1:0]          xi, yi;
  logic [MW-1:0]          addr, mem_waddr;
  logic                   mem_re, mem_we;
  logic [VW-1:0]          mem_wdata, rdata_q, new_val;
  logic [VW-1:0]          vdec;
  logic [VW:0]            vsum;
  logic signed [21:0]     limit;
  logic [AccW-1:0]        acc_mag, acc_sum;
  logic [CW-1:0]          rmag;

  logic [VW-1:0]          mem [Depth];

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ogr_pkg::ST_IDLE);

  ogr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && !in_i.req_type),
    .angle_i (in_i.pose_heading + in_i.beam_angle),
    .trig_o  (trig)
  );

  // cell window and address
  always_comb begin
    in_win = (cx_q >= -Half) && (cx_q < GRID_SIDE - Half) &&
             (cy_q >= -Half) && (cy_q < GRID_SIDE - Half);
    xi     = AW'(cx_q + CW'(Half));
    yi     = AW'(cy_q + CW'(Half));
    addr   = {xi, yi};
    // a straight beam visits a cell as one run
    skip   = !final_q && last_valid_q && (addr == last_addr_q);
    limit  = $signed({2'b0, range_q}) - $signed({6'b0, cell_size_q});
    more   = (n_q < NW'(MAX_RAY_STEPS)) && ($signed({1'b0, dist_q}) < limit);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ogr_pkg::ST_PX: begin
        mul_a = 26'(px_q);
        mul_b = $signed({2'b0, inv_cell_q});
      end
      ogr_pkg::ST_PY: begin
        mul_a = 26'(py_q);
        mul_b = $signed({2'b0, inv_cell_q});
      end
      ogr_pkg::ST_DC: begin
        mul_a = $signed({5'b0, d_q});
        mul_b = axis_q ? trig.sin_v : trig.cos_v;
      end
      ogr_pkg::ST_LO: begin
        mul_a = $signed({6'b0, prod_q[19:0]});
        mul_b = $signed({2'b0, inv_cell_q});
      end
      ogr_pkg::ST_HI: begin
        mul_a = 26'($signed(dc_q[38:20]));
        mul_b = $signed({2'b0, inv_cell_q});
      end
      default: ;
    endcase
    mul_p    = PW'(mul_a * mul_b);
    base_sel = axis_q ? basey_q : basex_q;
  end

  // cell index: round half away from zero, drop 36 bits
  always_comb begin
    acc_mag  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    acc_sum  = acc_mag + (AccW'(1) << 35);
    rmag     = acc_sum[36 +: CW];
    cell_rnd = acc_q[AccW-1] ? -$signed(rmag) : $signed(rmag);
  end

  // saturating cell update
  always_comb begin
    vdec = (rdata_q >= miss_dec_q) ? rdata_q - miss_dec_q : '0;
    if (vdec > cell_max_q) vdec = cell_max_q;
    vsum = {1'b0, rdata_q} + {1'b0, hit_inc_q};
    new_val = (vsum > {1'b0, cell_max_q}) ? cell_max_q : vsum[VW-1:0];
    if (!final_q) new_val = vdec;
  end

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = new_val;
    unique case (state_q)
      ogr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == '1) state_d = ogr_pkg::ST_IDLE;
      end
      ogr_pkg::ST_IDLE:
        if (in_acc) state_d = in_i.req_type ? ogr_pkg::ST_QADDR : ogr_pkg::ST_PX;
      ogr_pkg::ST_QADDR: begin
        mem_re  = in_win;
        state_d = ogr_pkg::ST_QDATA;
      end
      ogr_pkg::ST_QDATA:
        if (!out_valid_q || out_o.ready) state_d = ogr_pkg::ST_IDLE;
      ogr_pkg::ST_PX:    state_d = ogr_pkg::ST_PY;
      ogr_pkg::ST_PY:    state_d = ogr_pkg::ST_TRIG;
      ogr_pkg::ST_TRIG:  if (trig.done) state_d = ogr_pkg::ST_CHECK;
      ogr_pkg::ST_CHECK: state_d = ogr_pkg::ST_DC;
      ogr_pkg::ST_DC:    state_d = ogr_pkg::ST_LO;
      ogr_pkg::ST_LO:    state_d = ogr_pkg::ST_HI;
      ogr_pkg::ST_HI:    state_d = ogr_pkg::ST_ACC;
      ogr_pkg::ST_ACC:   state_d = ogr_pkg::ST_RND;
      ogr_pkg::ST_RND:   state_d = axis_q ? ogr_pkg::ST_ADDR : ogr_pkg::ST_DC;
      ogr_pkg::ST_ADDR: begin
        if (in_win && !skip) begin
          mem_re  = 1'b1;
          state_d = ogr_pkg::ST_MOD;
        end else begin
          state_d = final_q ? ogr_pkg::ST_IDLE : ogr_pkg::ST_CHECK;
        end
      end
      ogr_pkg::ST_MOD: begin
        mem_we  = 1'b1;
        state_d = final_q ? ogr_pkg::ST_IDLE : ogr_pkg::ST_CHECK;
      end
      default: state_d = ogr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ogr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      dist_q       <= '0;
      n_q          <= '0;
      axis_q       <= 1'b0;
      final_q      <= 1'b0;
      last_valid_q <= 1'b0;
      last_addr_q  <= '0;
      qwin_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ogr_pkg::ST_QDATA && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ogr_pkg::ST_CLEAR: clr_q <= clr_q + MW'(1);
        ogr_pkg::ST_IDLE:
          if (in_acc && !in_i.req_type) begin
            dist_q       <= '0;
            n_q          <= '0;
            final_q      <= 1'b0;
            last_valid_q <= 1'b0;
          end
        ogr_pkg::ST_QADDR: qwin_q <= in_win;
        ogr_pkg::ST_CHECK: begin
          axis_q <= 1'b0;
          if (!more) final_q <= 1'b1;
        end
        ogr_pkg::ST_RND: axis_q <= 1'b1;
        ogr_pkg::ST_ADDR:
          if (!(in_win && !skip) && !final_q) begin
            dist_q <= dist_q + DW'(ray_step_q);
            n_q    <= n_q + NW'(1);
          end
        ogr_pkg::ST_MOD:
          if (!final_q) begin
            last_addr_q  <= addr;
            last_valid_q <= 1'b1;
            dist_q       <= dist_q + DW'(ray_step_q);
            n_q          <= n_q + NW'(1);
          end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ogr_pkg::ST_IDLE:
        if (in_acc) begin
          px_q    <= in_i.pose_x;
          py_q    <= in_i.pose_y;
          range_q <= in_i.beam_range;
          cx_q    <= CW'(in_i.query_x);
          cy_q    <= CW'(in_i.query_y);
        end
      ogr_pkg::ST_QDATA:
        if (!out_valid_q || out_o.ready) begin
          out_val_q <= qwin_q ? rdata_q : '0;
          out_win_q <= qwin_q;
        end
      ogr_pkg::ST_PX: prod_q <= mul_p;
      ogr_pkg::ST_PY: begin
        basex_q <= prod_q[BW-1:0];
        prod_q  <= mul_p;
      end
      ogr_pkg::ST_TRIG: basey_q <= prod_q[BW-1:0];
      ogr_pkg::ST_CHECK: d_q <= more ? dist_q : DW'(range_q);
      ogr_pkg::ST_DC: prod_q <= mul_p;
      ogr_pkg::ST_LO: begin
        dc_q   <= prod_q[38:0];
        prod_q <= mul_p;
      end
      ogr_pkg::ST_HI: begin
        acc_q  <= (AccW'(base_sel) <<< 16) + AccW'(prod_q);
        prod_q <= mul_p;
      end
      ogr_pkg::ST_ACC: acc_q <= acc_q + (AccW'(prod_q) <<< 20);
      ogr_pkg::ST_RND:
        if (!axis_q) cx_q <= cell_rnd;
        else         cy_q <= cell_rnd;
      default: ;
    endcase
  end

  // grid memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[addr];
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_value = out_val_q;
  assign out_o.in_window  = out_win_q;

endmodule

// File: rtl/ogr_checker.sv
module ogr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] cell_value_i,
  input logic       in_window_i
);

  // a held result must stay offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // outside the grid reads back zero
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_window_i |-> cell_value_i == 7'd0)
    else $error("nonzero value for cell outside window");

  // ready drops after every accepted item, so items are never taken back to back
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted back to back");

endmodule

bind occupancy_grid_ray_update_unit ogr_checker u_ogr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cell_value_i (out_o.cell_value),
  .in_window_i  (out_o.in_window)
);

// File: sim/ogr_grid_checker.sv
module ogr_grid_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ogr_in_if           in_m,
  ogr_out_if          out_m,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side     = 256;
  localparam int MaxSteps = 1024;
  localparam int AtanTab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct {
    logic [6:0] value;
    logic       inw;
  } cell_read_t;

  logic [6:0]  occ [0:Side*Side-1];
  cell_read_t  reads_q [$];
  longint      inv_cell, cell_sz, step;
  int          miss_dec, hit_inc, val_max;

  assign pending_o = reads_q.size();

  function automatic longint rnd_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // sin/cos in Q1.16, folded into the right half-plane first
  function automatic void beam_trig(input logic [15:0] ang, output longint c,
                                    output longint s);
    int     z;
    bit     neg;
    longint x, y, nx;
    z   = int'(ang);
    neg = 1'b0;
    x   = 652032874;
    y   = 0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      neg = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      neg = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanTab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanTab[i];
      end
      x = nx;
    end
    x = rnd_shift(x, 14);
    y = rnd_shift(y, 14);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic bit cell_of(input longint ux, input longint uy, output int addr);
    longint cx, cy;
    cx = rnd_shift(ux * inv_cell, 36);
    cy = rnd_shift(uy * inv_cell, 36);
    addr = 0;
    if (cx < -Side/2 || cx >= Side/2 || cy < -Side/2 || cy >= Side/2) return 1'b0;
    addr = int'(cx + Side/2) * Side + int'(cy + Side/2);
    return 1'b1;
  endfunction

  function automatic void bump(int addr, int dv);
    int v;
    v = int'(occ[addr]) + dv;
    if (v < 0) v = 0;
    if (v > val_max) v = val_max;
    occ[addr] = v[6:0];
  endfunction

  function automatic void cast_beam(logic signed [23:0] pxi, logic signed [23:0] pyi,
                                    logic [15:0] hd, logic [15:0] ba, logic [19:0] rg);
    longint px, py, c, s, rng, lim, d;
    int     addr, last;
    bit     have_last;
    logic [15:0] ang;
    px  = longint'(pxi) * 65536;
    py  = longint'(pyi) * 65536;
    ang = hd + ba;
    rng = longint'(rg);
    lim = rng - cell_sz;
    beam_trig(ang, c, s);
    have_last = 1'b0;
    last = 0;
    d = 0;
    for (int n = 0; n < MaxSteps && d < lim; n++) begin
      if (cell_of(px + d * c, py + d * s, addr)) begin
        // a straight beam passes each cell in one run
        if (!have_last || addr != last) begin
          bump(addr, -miss_dec);
          last = addr;
          have_last = 1'b1;
        end
      end
      d += step;
    end
    if (cell_of(px + rng * c, py + rng * s, addr)) bump(addr, hit_inc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_read_t exp_rd;
    int         addr;
    if (!rst_ni) begin
      for (int i = 0; i < Side*Side; i++) occ[i] = '0;
      reads_q.delete();
      errors_o = 0;
      inv_cell = 1024;
      cell_sz  = 1024;
      step     = 410;
      miss_dec = 2;
      hit_inc  = 5;
      val_max  = 100;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (reads_q.size() == 0) begin
          $display("%0t: unexpected cell read value=%0d in_window=%0b", $time,
                   out_m.cell_value, out_m.in_window);
          errors_o++;
        end else begin
          exp_rd = reads_q.pop_front();
          if (out_m.cell_value !== exp_rd.value) begin
            $display("%0t: cell_value expected %0d actual %0d", $time, exp_rd.value,
                     out_m.cell_value);
            errors_o++;
          end
          if (out_m.in_window !== exp_rd.inw) begin
            $display("%0t: in_window expected %0b actual %0b", $time, exp_rd.inw,
                     out_m.in_window);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (ogr_pkg::cfg_idx_e'(cfg_idx_i))
          ogr_pkg::CFG_INV_CELL:  inv_cell = longint'(cfg_data_i);
          ogr_pkg::CFG_CELL_SIZE: cell_sz  = longint'(cfg_data_i);
          ogr_pkg::CFG_RAY_STEP:  step     = longint'(cfg_data_i);
          ogr_pkg::CFG_MISS_DEC:  miss_dec = int'(cfg_data_i[6:0]);
          ogr_pkg::CFG_HIT_INC:   hit_inc  = int'(cfg_data_i[6:0]);
          ogr_pkg::CFG_CELL_MAX:  val_max  = int'(cfg_data_i[6:0]);
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.req_type) begin
          if (in_m.query_x >= -Side/2 && in_m.query_x < Side/2 &&
              in_m.query_y >= -Side/2 && in_m.query_y < Side/2) begin
            addr = (int'(in_m.query_x) + Side/2) * Side + int'(in_m.query_y) + Side/2;
            exp_rd.value = occ[addr];
            exp_rd.inw   = 1'b1;
          end else begin
            exp_rd.value = '0;
            exp_rd.inw   = 1'b0;
          end
          reads_q = {reads_q, exp_rd};
        end else begin
          cast_beam(in_m.pose_x, in_m.pose_y, in_m.pose_heading, in_m.beam_angle,
                    in_m.beam_range);
        end
      end
    end
  end

endmodule

// File: sim/tb_occupancy_grid_ray_update_unit.sv
module tb_occupancy_grid_ray_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 300000;
  localparam int PerPhase  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          calm;
  bit          hold_req;
  int          cur_step;

  ogr_in_if  in_i ();
  ogr_out_if out_o ();

  occupancy_grid_ray_update_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ogr_grid_checker grid_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_m       (in_i),
    .out_m      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("occupancy_grid_ray_update_unit regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_o.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_o.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_o.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_o.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic push_item(logic rt, logic signed [23:0] px, logic signed [23:0] py,
                           logic [15:0] hd, logic [15:0] ba, logic [19:0] rg,
                           logic signed [7:0] qx, logic signed [7:0] qy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_i.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_i.valid        <= 1'b1;
    in_i.req_type     <= rt;
    in_i.pose_x       <= px;
    in_i.pose_y       <= py;
    in_i.pose_heading <= hd;
    in_i.beam_angle   <= ba;
    in_i.beam_range   <= rg;
    in_i.query_x      <= qx;
    in_i.query_y      <= qy;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  task automatic send_hit(logic signed [23:0] px, logic signed [23:0] py,
                          logic [15:0] hd, logic [15:0] ba, logic [19:0] rg);
    push_item(1'b0, px, py, hd, ba, rg, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_read(logic signed [7:0] qx, logic signed [7:0] qy);
    push_item(1'b1, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
              20'($urandom), qx, qy);
  endtask

  // a read behind the last hit proves the block is idle once it returns
  task automatic drain;
    send_read(8'($urandom), 8'($urandom));
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(int inv, int csz, int stp, int miss, int hit, int vmax);
    ogr_pkg::cfg_idx_e idx [6] = '{ogr_pkg::CFG_INV_CELL, ogr_pkg::CFG_CELL_SIZE,
                                   ogr_pkg::CFG_RAY_STEP, ogr_pkg::CFG_MISS_DEC,
                                   ogr_pkg::CFG_HIT_INC, ogr_pkg::CFG_CELL_MAX};
    int       val [6];
    val = '{inv, csz, stp, miss, hit, vmax};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= 16'(val[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_step = stp;
  endtask

  function automatic logic [19:0] pick_range();
    longint lim;
    int     r;
    r = $urandom_range(0, 99);
    if (r == 0) return 20'($urandom);
    lim = longint'(cur_step) * ((r < 6) ? 200 : 40);
    if (lim < 64) lim = 64;
    if (lim > 1048575) lim = 1048575;
    return 20'($urandom_range(0, int'(lim)));
  endfunction

  function automatic logic signed [23:0] pick_pose();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 65536)) - 32768);
  endfunction

  function automatic logic signed [7:0] pick_query();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(0, 80)) - 40);
  endfunction

  task automatic random_item;
    if ($urandom_range(0, 1) == 0) begin
      send_hit(pick_pose(), pick_pose(), 16'($urandom), 16'($urandom), pick_range());
    end else begin
      send_read(pick_query(), pick_query());
    end
  endtask

  initial begin
    int cfgs [6][6] = '{
      '{1024, 1024, 410, 2, 5, 100},
      '{65535, 65535, 65535, 127, 127, 127},
      '{1, 1, 1, 0, 0, 1},
      '{512, 2048, 820, 10, 20, 60},
      '{2048, 512, 205, 1, 3, 127},
      '{1024, 1024, 410, 7, 9, 90}
    };
    rst_ni            = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= ogr_pkg::CFG_INV_CELL;
    cfg_data_i        <= '0;
    in_i.valid        <= 1'b0;
    in_i.req_type     <= 1'b0;
    in_i.pose_x       <= '0;
    in_i.pose_y       <= '0;
    in_i.pose_heading <= '0;
    in_i.beam_angle   <= '0;
    in_i.beam_range   <= '0;
    in_i.query_x      <= '0;
    in_i.query_y      <= '0;
    calm              = 1'b0;
    cur_step          = 410;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: window corners, axis angles, short and overlong beams
    send_read(-8'sd128, -8'sd128);
    send_read(8'sd127, 8'sd127);
    send_hit(24'sd0, 24'sd0, 16'd0, 16'd0, 20'd0);
    send_hit(24'sd0, 24'sd0, 16'd16384, 16'd0, 20'd1024);
    send_hit(24'sd0, 24'sd0, 16'd0, 16'd32768, 20'd8192);
    send_hit(24'sd4096, -24'sd4096, 16'd49152, 16'd65535, 20'd20480);
    send_hit(24'sd0, 24'sd0, 16'd65535, 16'd65535, 20'hFFFFF);
    send_hit(-24'sd8388608, 24'sd8388607, 16'd8192, 16'd0, 20'd40960);
    send_hit(24'sd8388607, -24'sd8388608, 16'd0, 16'd24576, 20'd4096);
    send_read(8'sd0, 8'sd0);
    send_read(8'sd0, 8'sd2);
    send_read(-8'sd2, 8'sd0);
    send_read(8'sd5, 8'sd0);
    drain();
    // zero ray_step and zero inv_cell_size
    write_regs(0, 1024, 0, 3, 4, 100);
    send_hit(24'sd4096, 24'sd4096, 16'd100, 16'd200, 20'd30000);
    send_hit(24'sd0, 24'sd0, 16'd300, 16'd0, 20'd3000);
    send_read(8'sd0, 8'sd0);
    drain();
    write_regs(1024, 1024, 0, 3, 4, 100);
    send_hit(24'sd4096, 24'sd4096, 16'd100, 16'd200, 20'd30000);
    send_read(8'sd4, 8'sd4);
    send_read(8'sd5, 8'sd4);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4],
                 cfgs[p][5]);
      for (int k = 0; k < PerPhase; k++) begin
        if (p == 0 && k == 100) begin
          // receiver holds off while reads pile up behind the output register
          hold_req = 1'b1;
          for (int j = 0; j < 20; j++) send_read(pick_query(), pick_query());
        end
        if (p == 5 && k == PerPhase - 150) calm = 1'b1;
        random_item();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("occupancy_grid_ray_update_unit regression: pass");
    end else begin
      $display("occupancy_grid_ray_update_unit regression: fail");
    end
    $finish;
  end

endmodule
